>>> src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mwrf_pkg.sv
// shared types, constants and crc function for the modbus write-register framer
package mwrf_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned IDX_W = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] SLAVE_RESET = 8'h01;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0] slave;
		logic [15:0] addr;
		logic [15:0] val;
		logic [15:0] crc;
	} frame_t;

	// crc-16/modbus update by one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> src/mwrf_crc_pipe.sv
// three-stage crc pipeline, two frame bytes folded into the crc per stage
module mwrf_crc_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] slave,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] in_addr,
	input  logic [15:0] in_val,
	output logic out_valid,
	input  logic out_ready,
	output mwrf_pkg::frame_t out_frame
);
	import mwrf_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	frame_t f_s1, f_s2, f_s3;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// slave address and function code
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			f_s1.slave <= slave;
			f_s1.addr <= in_addr;
			f_s1.val <= in_val;
			f_s1.crc <= crc_byte(crc_byte(CRC_INIT, slave), FUNC_WRITE_SINGLE);
		end
	end

	// register address bytes
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			f_s2.slave <= f_s1.slave;
			f_s2.addr <= f_s1.addr;
			f_s2.val <= f_s1.val;
			f_s2.crc <= crc_byte(crc_byte(f_s1.crc, f_s1.addr[15:8]), f_s1.addr[7:0]);
		end
	end

	// value bytes
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			f_s3.slave <= f_s2.slave;
			f_s3.addr <= f_s2.addr;
			f_s3.val <= f_s2.val;
			f_s3.crc <= crc_byte(crc_byte(f_s2.crc, f_s2.val[15:8]), f_s2.val[7:0]);
		end
	end

	assign out_valid = v_s3;
	assign out_frame = f_s3;

endmodule

>>> src/mwrf_serializer.sv
// frame register and byte serializer
module mwrf_serializer (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mwrf_pkg::frame_t in_frame,
	output logic m_valid,
	input  logic m_ready,
	output logic [7:0] m_byte,
	output logic m_last
);
	import mwrf_pkg::*;

	frame_t frame_q;
	logic busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] bytes [FRAME_LEN];
	logic take;

	assign in_ready = !busy_q || (m_ready && idx_q == LAST_IDX);
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && m_ready) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) frame_q <= in_frame;
	end

	always_comb begin
		bytes[0] = frame_q.slave;
		bytes[1] = FUNC_WRITE_SINGLE;
		bytes[2] = frame_q.addr[15:8];
		bytes[3] = frame_q.addr[7:0];
		bytes[4] = frame_q.val[15:8];
		bytes[5] = frame_q.val[7:0];
		bytes[6] = frame_q.crc[7:0];
		bytes[7] = frame_q.crc[15:8];
	end

	assign m_valid = busy_q;
	assign m_byte = bytes[idx_q];
	assign m_last = (idx_q == LAST_IDX);

endmodule

>>> src/modbus_write_register_framer.sv
// modbus rtu write-single-register framer top level
// a request crosses the crc stages and the frame register before its first byte
// bytes go one per cycle while m_axis_tready is high; a new frame is taken as
// the last byte goes; the 3-stage crc pipeline takes requests until it is full
// reset: async active low, clears all valid bits and sets slave_address to 0x01
module modbus_write_register_framer (
	input  logic clk,
	input  logic arst_n,
	input  logic slave_address_we,
	input  logic [7:0] slave_address_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // register_address[15:0], register_value[31:16]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [7:0] m_axis_tdata,   // frame_byte[7:0]
	output logic m_axis_tlast          // last_byte
);
	import mwrf_pkg::*;

	logic [7:0] slave_q;
	logic pipe_valid;
	logic pipe_ready;
	frame_t pipe_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_RESET;
		end else if (slave_address_we) begin
			slave_q <= slave_address_wdata;
		end
	end

	mwrf_crc_pipe u_crc (
		.clk(clk),
		.arst_n(arst_n),
		.slave(slave_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_addr(s_axis_tdata[15:0]),
		.in_val(s_axis_tdata[31:16]),
		.out_valid(pipe_valid),
		.out_ready(pipe_ready),
		.out_frame(pipe_frame)
	);

	mwrf_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pipe_valid),
		.in_ready(pipe_ready),
		.in_frame(pipe_frame),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_byte(m_axis_tdata),
		.m_last(m_axis_tlast)
	);

endmodule

>>> src/mwrf_checker.sv
// port-level checker for the framer, bound to the top level
`include "assert_macros.svh"

module mwrf_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic m_axis_tlast
);
	import mwrf_pkg::*;

	logic [IDX_W-1:0] pos_q;
	logic m_take;

	assign m_take = m_axis_tvalid && m_axis_tready;

	// position of the next output byte within its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (m_take) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	`ASSERT_CLK(a_out_hold, clk, arst_n,
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"output changed while stalled")
	`ASSERT_CLK(a_last_pos, clk, arst_n,
		m_take |-> (m_axis_tlast == (pos_q == LAST_IDX)), "tlast not on eighth byte")
	`ASSERT_CLK(a_func_code, clk, arst_n,
		m_take && pos_q == IDX_W'(1) |-> m_axis_tdata == FUNC_WRITE_SINGLE, "bad function code")
	`ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind modbus_write_register_framer mwrf_checker u_mwrf_checker (.*);
